>>> src/pga_pkg.sv
// Package for the polygon area and bounding box accumulator.
// Holds the shared widths, flag structs and the saturating add; no dependencies.
package pga_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int ACC_W          = 64;
  localparam int AREA_W         = 62;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic signed [ACC_W-1:0] ACC_MAX   = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN   = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] ACC_FLOOR = 64'sd2;

  // Flags of one incoming vertex.
  typedef struct packed {
    logic batch_end;
    logic path_end;
    logic clear_totals;
    logic batch_start;
  } vtx_flags_t;

  // Flags the back end still needs once the edge terms are formed.
  typedef struct packed {
    logic batch_end;
    logic clear_totals;
    logic batch_start;
  } job_flags_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] sum;
    logic                    ovf;
  } acc_t;

  // Add with saturation at the signed accumulator limits.
  function automatic acc_t sat_add(input logic signed [ACC_W-1:0] a,
                                   input logic signed [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    acc_t           r;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      r.ovf = 1'b1;
      r.sum = s[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      r.ovf = 1'b0;
      r.sum = s[ACC_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> src/pga_front.sv
// Front end: path tracking, edge products and bounding box per vertex.
// Depends on pga_pkg.
module pga_front #(
  parameter int COORD_BITS = pga_pkg::COORD_BITS_DEF,
  parameter int TERM_W     = 2 * COORD_BITS + 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic signed [COORD_BITS-1:0] vertex_x,
  input  logic signed [COORD_BITS-1:0] vertex_y,
  input  pga_pkg::vtx_flags_t          vflags,
  output logic signed [TERM_W-1:0]     term_a,
  output logic signed [TERM_W-1:0]     term_b,
  output logic [4*COORD_BITS-1:0]      box,
  output pga_pkg::job_flags_t          jflags
);

  localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic signed [COORD_BITS-1:0] prev_x, prev_y, first_x, first_y;
  logic signed [COORD_BITS-1:0] min_x, max_x, min_y, max_y;
  logic                         in_path, path_negative;

  logic signed [COORD_BITS-1:0] first_x_next, first_y_next;
  logic signed [COORD_BITS-1:0] min_x_next, max_x_next, min_y_next, max_y_next;
  logic                         neg_eff, open_eff, closing;
  logic signed [COORD_BITS:0]   fa_sum, fa_dif, fb_sum, fb_dif;
  logic signed [TERM_W-1:0]     prod_a, prod_b;

  always_comb begin
    neg_eff  = vflags.batch_start ? 1'b0 : path_negative;
    open_eff = vflags.batch_start ? 1'b0 : in_path;
    closing  = vflags.path_end | vflags.batch_end;

    first_x_next = open_eff ? first_x : vertex_x;
    first_y_next = open_eff ? first_y : vertex_y;

    // Edge from the previous vertex, and the closing edge back to the first.
    fa_sum = {vertex_y[COORD_BITS-1], vertex_y} + {prev_y[COORD_BITS-1], prev_y};
    fa_dif = {vertex_x[COORD_BITS-1], vertex_x} - {prev_x[COORD_BITS-1], prev_x};
    fb_sum = {first_y_next[COORD_BITS-1], first_y_next} + {vertex_y[COORD_BITS-1], vertex_y};
    fb_dif = {first_x_next[COORD_BITS-1], first_x_next} - {vertex_x[COORD_BITS-1], vertex_x};
    prod_a = fa_sum * fa_dif;
    prod_b = fb_sum * fb_dif;

    term_a = open_eff ? (neg_eff ? -prod_a : prod_a) : '0;
    term_b = closing ? (neg_eff ? -prod_b : prod_b) : '0;

    if (vflags.batch_start && vflags.clear_totals) begin
      min_x_next = vertex_x;
      max_x_next = vertex_x;
      min_y_next = vertex_y;
      max_y_next = vertex_y;
    end else begin
      min_x_next = (vertex_x < min_x) ? vertex_x : min_x;
      max_x_next = (vertex_x > max_x) ? vertex_x : max_x;
      min_y_next = (vertex_y < min_y) ? vertex_y : min_y;
      max_y_next = (vertex_y > max_y) ? vertex_y : max_y;
    end

    box = {max_y_next, min_y_next, max_x_next, min_x_next};
    jflags.batch_end    = vflags.batch_end;
    jflags.clear_totals = vflags.clear_totals;
    jflags.batch_start  = vflags.batch_start;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x        <= '0;
      prev_y        <= '0;
      first_x       <= '0;
      first_y       <= '0;
      in_path       <= 1'b0;
      path_negative <= 1'b0;
      min_x         <= CMAX;
      max_x         <= CMIN;
      min_y         <= CMAX;
      max_y         <= CMIN;
    end else if (accept) begin
      prev_x        <= vertex_x;
      prev_y        <= vertex_y;
      first_x       <= first_x_next;
      first_y       <= first_y_next;
      in_path       <= ~closing;
      path_negative <= closing ? ~neg_eff : neg_eff;
      min_x         <= min_x_next;
      max_x         <= max_x_next;
      min_y         <= min_y_next;
      max_y         <= max_y_next;
    end
  end

endmodule

>>> src/pga_queue.sv
// Short register queue between the front and back ends.
// Depends on nothing outside itself.
module pga_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push, do_pop;

  assign full     = (count == CW'(DEPTH));
  assign valid    = (count != '0);
  assign pop_data = entries[rd_ptr];
  assign do_push  = push & ~full;
  assign do_pop   = pop & valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

endmodule

>>> src/pga_back.sv
// Back end: saturating area accumulation, result formation and output register.
// Depends on pga_pkg.
module pga_back #(
  parameter int COORD_BITS = pga_pkg::COORD_BITS_DEF,
  parameter int TERM_W     = 2 * COORD_BITS + 2
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  input  logic signed [TERM_W-1:0]         term_a,
  input  logic signed [TERM_W-1:0]         term_b,
  input  logic [4*COORD_BITS-1:0]          box,
  input  pga_pkg::job_flags_t              jflags,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [pga_pkg::AREA_W-1:0]       out_area,
  output logic [4*COORD_BITS-1:0]          out_box,
  output logic                             out_sat
);

  localparam int EXT = pga_pkg::ACC_W - TERM_W;

  logic signed [pga_pkg::ACC_W-1:0] area_sum, base, ext_a, ext_b, final_sum;
  logic                             sat_flag, sat_base;
  pga_pkg::acc_t                    s1, s2;

  always_comb begin
    q_pop    = q_valid & (~jflags.batch_end | ~out_valid | out_ready);
    base     = (jflags.batch_start && jflags.clear_totals) ? '0 : area_sum;
    sat_base = jflags.batch_start ? 1'b0 : sat_flag;
    ext_a    = {{EXT{term_a[TERM_W-1]}}, term_a};
    ext_b    = {{EXT{term_b[TERM_W-1]}}, term_b};
    // Path edge first, then the closing edge, as two ordered saturating adds.
    s1 = pga_pkg::sat_add(base, ext_a);
    s2 = pga_pkg::sat_add(s1.sum, ext_b);
    final_sum = s2.sum;
    if (jflags.batch_end && (s2.sum < pga_pkg::ACC_FLOOR)) final_sum = pga_pkg::ACC_FLOOR;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      area_sum  <= '0;
      sat_flag  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        area_sum <= final_sum;
        sat_flag <= sat_base | s1.ovf | s2.ovf;
      end
      if (q_pop && jflags.batch_end) out_valid <= 1'b1;
      else if (out_ready)            out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && jflags.batch_end) begin
      out_area <= final_sum[pga_pkg::AREA_W:1];
      out_box  <= box;
      out_sat  <= sat_base | s1.ovf | s2.ovf;
    end
  end

endmodule

>>> src/polygon_area_bbox_accumulator_unit.sv
// A batch-end job is held in the queue, then its result in the back end output
// register. Throughput: one vertex per cycle while the queue has room, set by
// the front end multipliers and the single back end accumulate step; the queue
// absorbs output stalls until full. Reset: rst is synchronous, active high;
// clears path state, box, sum and the queue at once, no clearing pass.
module polygon_area_bbox_accumulator_unit #(
  parameter int COORD_BITS = pga_pkg::COORD_BITS_DEF,
  localparam int IN_W      = ((2 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W     = ((pga_pkg::AREA_W + 4 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst,
  // Vertex request channel.
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [IN_W-1:0]     s_tdata,  // vertex_x, vertex_y, zero pad
  input  logic [2:0]          s_tuser,  // batch_start, clear_totals, path_end
  input  logic                s_tlast,  // batch_end
  // Result channel.
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OUT_W-1:0]    m_tdata,  // area, box_min_x, box_max_x, box_min_y,
                                        // box_max_y, zero pad
  output logic [0:0]          m_tuser   // area_saturated
);

  localparam int TERM_W = 2 * COORD_BITS + 2;
  localparam int BOX_W  = 4 * COORD_BITS;
  localparam int JOB_W  = 2 * TERM_W + BOX_W + $bits(pga_pkg::job_flags_t);

  logic                         accept, q_full, q_valid, q_pop;
  pga_pkg::vtx_flags_t          vflags;
  pga_pkg::job_flags_t          f_flags, b_flags;
  logic signed [TERM_W-1:0]     f_term_a, f_term_b, b_term_a, b_term_b;
  logic [BOX_W-1:0]             f_box, b_box, out_box;
  logic [JOB_W-1:0]             q_in, q_out;
  logic [pga_pkg::AREA_W-1:0]   out_area;
  logic                         out_sat;

  // Accept a vertex whenever the queue has room.
  assign s_tready = ~q_full;
  assign accept   = s_tvalid & s_tready;

  assign vflags.batch_start  = s_tuser[0];
  assign vflags.clear_totals = s_tuser[1];
  assign vflags.path_end     = s_tuser[2];
  assign vflags.batch_end    = s_tlast;

  // Front end: classify the vertex and form its signed edge terms.
  pga_front #(
    .COORD_BITS (COORD_BITS),
    .TERM_W     (TERM_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .vertex_x (s_tdata[COORD_BITS-1:0]),
    .vertex_y (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .vflags   (vflags),
    .term_a   (f_term_a),
    .term_b   (f_term_b),
    .box      (f_box),
    .jflags   (f_flags)
  );

  // Queue registers the products, so no add follows a multiply in one cycle.
  assign q_in = {f_flags, f_box, f_term_b, f_term_a};

  pga_queue #(
    .WIDTH (JOB_W),
    .DEPTH (pga_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_out)
  );

  assign b_term_a = q_out[TERM_W-1:0];
  assign b_term_b = q_out[2*TERM_W-1:TERM_W];
  assign b_box    = q_out[2*TERM_W+BOX_W-1:2*TERM_W];
  assign b_flags  = q_out[JOB_W-1:2*TERM_W+BOX_W];

  // Back end: accumulate, clamp at batch end, hold the result until taken.
  pga_back #(
    .COORD_BITS (COORD_BITS),
    .TERM_W     (TERM_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .term_a    (b_term_a),
    .term_b    (b_term_b),
    .box       (b_box),
    .jflags    (b_flags),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_area  (out_area),
    .out_box   (out_box),
    .out_sat   (out_sat)
  );

  assign m_tdata    = OUT_W'({out_box, out_area});
  assign m_tuser[0] = out_sat;

endmodule

>>> src/pga_checker.sv
// Port-level checks for the polygon area and bounding box accumulator.
// Depends on pga_pkg; bound to the top level below.
module pga_checker #(
  parameter int COORD_BITS = pga_pkg::COORD_BITS_DEF,
  parameter int OUT_W      = 160
) (
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  localparam int A = pga_pkg::AREA_W;
  localparam int C = COORD_BITS;

  logic signed [C-1:0] bmin_x, bmax_x, bmin_y, bmax_y;

  assign bmin_x = m_tdata[A+C-1:A];
  assign bmax_x = m_tdata[A+2*C-1:A+C];
  assign bmin_y = m_tdata[A+3*C-1:A+2*C];
  assign bmax_y = m_tdata[A+4*C-1:A+3*C];

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result dropped or changed");

  a_area_floor: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[A-1:0] != '0)
    else $error("area below one LSB");

  a_box_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (bmin_x <= bmax_x) && (bmin_y <= bmax_y))
    else $error("box inverted on a result");

endmodule

bind polygon_area_bbox_accumulator_unit pga_checker #(
  .COORD_BITS (COORD_BITS),
  .OUT_W      (OUT_W)
) u_pga_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> verif/tb_polygon_area_bbox_accumulator_unit.sv
// Testbench for polygon_area_bbox_accumulator_unit: streams polygon vertices and
// checks every area/box result against an in-bench shoelace predictor or typed row.
// Depends on pga_pkg and the unit itself.
module tb_polygon_area_bbox_accumulator_unit;

  localparam int COORD_W      = pga_pkg::COORD_BITS_DEF;
  localparam int VTX_W        = 2 * COORD_W;
  localparam int OUT_W        = ((pga_pkg::AREA_W + 4 * COORD_W + 7) / 8) * 8;
  localparam int CMAX         = 2 ** (COORD_W - 1) - 1;
  localparam int CMIN         = -(2 ** (COORD_W - 1));
  localparam int DIR_ROWS     = 26;
  localparam int RANDOM_ITEMS = 1400;
  localparam int SWEEP_LAPS   = 64;
  localparam int HOLD_CYCLES  = 80;
  localparam longint RUN_LIMIT = 64'd15_000_000;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [pga_pkg::AREA_W-1:0] area;
    coord_t            min_x;
    coord_t            max_x;
    coord_t            min_y;
    coord_t            max_y;
    logic              sat;
  } area_box_t;

  // One vertex request; chk marks a directed row whose result is typed in.
  typedef struct packed {
    coord_t    x;
    coord_t    y;
    logic      batch_start;
    logic      clear_totals;
    logic      path_end;
    logic      batch_end;
    logic      chk;
    area_box_t fixed;
  } vertex_req_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [VTX_W-1:0]   s_tdata;
  logic [2:0]         s_tuser;
  logic               s_tlast;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [OUT_W-1:0]   m_tdata;
  logic [0:0]         m_tuser;
  vertex_req_t        drv = '0;

  assign s_tdata = {drv.y, drv.x};
  assign s_tuser = {drv.path_end, drv.clear_totals, drv.batch_start};
  assign s_tlast = drv.batch_end;

  polygon_area_bbox_accumulator_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shoelace predictor state: twice the area, open path, bounding box.
  longint acc2 = 0;
  longint last_x = 0, last_y = 0, start_x = 0, start_y = 0;
  bit     open_path = 1'b0, hole_sign = 1'b0, acc_sat = 1'b0;
  longint bx_lo = CMAX, bx_hi = CMIN, by_lo = CMAX, by_hi = CMIN;

  area_box_t   pending_areas [$];
  int unsigned mismatches = 0;
  int unsigned vertices_in = 0;
  int unsigned results_seen = 0;
  int unsigned sat_results = 0;
  int unsigned input_stalls = 0;
  int unsigned vertices_offered = 0;
  int unsigned hold_ask = 0;
  bit          sender_calm = 1'b0;

  // Add one trapezoid term with signed 64-bit saturation.
  function automatic void add_trapezoid(longint x0, longint y0, longint x1, longint y1);
    longint term;
    term = (y1 + y0) * (x1 - x0);
    if (hole_sign) term = -term;
    if (term > 0 && acc2 > longint'(pga_pkg::ACC_MAX) - term) begin
      acc2    = pga_pkg::ACC_MAX;
      acc_sat = 1'b1;
    end else if (term < 0 && acc2 < longint'(pga_pkg::ACC_MIN) - term) begin
      acc2    = pga_pkg::ACC_MIN;
      acc_sat = 1'b1;
    end else begin
      acc2 += term;
    end
  endfunction

  function automatic bit shoelace_predict(input vertex_req_t v, output area_box_t r);
    longint x, y;
    x = v.x;
    y = v.y;
    r = '0;
    if (v.batch_start) begin
      hole_sign = 1'b0;
      open_path = 1'b0;
      acc_sat   = 1'b0;
      if (v.clear_totals) begin
        acc2  = 0;
        bx_lo = CMAX;
        bx_hi = CMIN;
        by_lo = CMAX;
        by_hi = CMIN;
      end
    end
    if (x < bx_lo) bx_lo = x;
    if (x > bx_hi) bx_hi = x;
    if (y < by_lo) by_lo = y;
    if (y > by_hi) by_hi = y;
    if (!open_path) begin
      start_x   = x;
      start_y   = y;
      open_path = 1'b1;
    end else begin
      add_trapezoid(last_x, last_y, x, y);
    end
    last_x = x;
    last_y = y;
    // Close the path on path end, or implicitly on batch end.
    if (v.path_end || v.batch_end) begin
      add_trapezoid(last_x, last_y, start_x, start_y);
      hole_sign = !hole_sign;
      open_path = 1'b0;
    end
    if (!v.batch_end) return 1'b0;
    if (acc2 < 2) acc2 = 2;
    r.area  = acc2[pga_pkg::AREA_W:1];
    r.min_x = bx_lo[COORD_W-1:0];
    r.max_x = bx_hi[COORD_W-1:0];
    r.min_y = by_lo[COORD_W-1:0];
    r.max_y = by_hi[COORD_W-1:0];
    r.sat   = acc_sat;
    return 1'b1;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Predict on every accepted vertex, compare on every accepted result.
  always @(posedge clk) begin
    area_box_t want, got;
    if (!rst) begin
      if (s_tvalid && !s_tready) input_stalls++;
      if (s_tvalid && s_tready) begin
        vertices_in++;
        if (shoelace_predict(drv, want)) begin
          if (drv.chk) want = drv.fixed;
          pending_areas.push_back(want);
        end
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        got.area  = m_tdata[pga_pkg::AREA_W-1:0];
        got.min_x = m_tdata[pga_pkg::AREA_W +: COORD_W];
        got.max_x = m_tdata[pga_pkg::AREA_W + COORD_W +: COORD_W];
        got.min_y = m_tdata[pga_pkg::AREA_W + 2 * COORD_W +: COORD_W];
        got.max_y = m_tdata[pga_pkg::AREA_W + 3 * COORD_W +: COORD_W];
        got.sat   = m_tuser[0];
        if (pending_areas.size() == 0) begin
          $error("result arrived with no batch pending");
          mismatches++;
        end else begin
          want = pending_areas.pop_front();
          if (want.sat) sat_results++;
          check_field("area", 64'(want.area), 64'(got.area));
          check_field("box_min_x", 64'(want.min_x), 64'(got.min_x));
          check_field("box_max_x", 64'(want.max_x), 64'(got.max_x));
          check_field("box_min_y", 64'(want.min_y), 64'(got.min_y));
          check_field("box_max_y", 64'(want.max_y), 64'(got.max_y));
          check_field("area_saturated", 64'(want.sat), 64'(got.sat));
        end
      end
    end
  end

  // Mostly short idle stretches, a few long ones.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic coord_t pick_coord(int mode);
    case (mode)
      0: return coord_t'(int'($urandom_range(0, 4000)) - 2000);
      1: return coord_t'($urandom);
      default: begin
        case ($urandom_range(0, 4))
          0: return coord_t'(CMIN);
          1: return coord_t'(CMAX);
          2: return '0;
          3: return '1;
          default: return coord_t'(1);
        endcase
      end
    endcase
  endfunction

  // Entered and left in a falling-edge step with no drive pending.
  task automatic send_vertex(input vertex_req_t v);
    int gap;
    gap = (sender_calm || (vertices_offered / 128) % 4 == 0) ? 0 : pick_idle();
    repeat (gap) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    drv      <= v;
    vertices_offered++;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Trace the full-range rectangle over and over inside one open path, so
  // every lap adds about 2^49 of the same sign and the sum reaches its
  // upper bits.
  task automatic sweep_to_limit(input bit upward);
    vertex_req_t v;
    int          ord [4];
    if (upward) ord = '{0, 1, 2, 3};
    else        ord = '{0, 3, 2, 1};
    sender_calm = 1'b1;
    for (int lap = 0; lap < SWEEP_LAPS; lap++) begin
      for (int k = 0; k < 4; k++) begin
        v = '0;
        v.x = (ord[k] == 0 || ord[k] == 3) ? coord_t'(CMIN) : coord_t'(CMAX);
        v.y = (ord[k] <= 1) ? coord_t'(CMAX) : coord_t'(CMIN);
        v.batch_start  = (lap == 0 && k == 0);
        v.clear_totals = v.batch_start;
        v.batch_end    = (lap == SWEEP_LAPS - 1 && k == 3);
        send_vertex(v);
      end
    end
    sender_calm = 1'b0;
  endtask

  // Batch of 1..3 paths, well formed unless cut short (up to one in ten); some let
  // the batch end close the last path.
  task automatic random_batch(inout int sent);
    vertex_req_t v;
    int          mode, paths, nverts, cut, here;
    bit          close_last, path_last, batch_last;
    here       = 0;
    mode       = $urandom_range(0, 9);
    mode       = (mode < 5) ? 0 : (mode < 8) ? 1 : 2;
    paths      = $urandom_range(1, 3);
    cut        = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : 0;
    close_last = ($urandom_range(0, 3) != 0);
    for (int p = 0; p < paths; p++) begin
      nverts = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
      for (int k = 0; k < nverts; k++) begin
        v = '0;
        v.x            = pick_coord(mode);
        v.y            = pick_coord(mode);
        v.batch_start  = (p == 0 && k == 0);
        v.clear_totals = v.batch_start && ($urandom_range(0, 3) != 0);
        path_last      = (k == nverts - 1);
        batch_last     = path_last && (p == paths - 1);
        v.path_end     = path_last && (!batch_last || close_last);
        v.batch_end    = batch_last;
        send_vertex(v);
        sent++;
        here++;
        if (cut != 0 && here == cut) return;
      end
    end
  endtask

  // Directed rows: x, y, batch_start, clear_totals, path_end, batch_end, chk,
  // typed result {area, min_x, max_x, min_y, max_y, saturated}.
  vertex_req_t dir_table [DIR_ROWS] = '{
    // append to the reset state, single vertex: area clamps to one LSB
    '{5, 7, 1, 0, 0, 1, 1, '{1, 5, 5, 7, 7, 0}},
    // clockwise 4x4 square
    '{0, 0, 1, 1, 0, 0, 0, '0},
    '{0, 4, 0, 0, 0, 0, 0, '0},
    '{4, 4, 0, 0, 0, 0, 0, '0},
    '{4, 0, 0, 0, 0, 1, 1, '{16, 0, 4, 0, 4, 0}},
    // 8x8 outer square with a 2x2 hole
    '{0, 0, 1, 1, 0, 0, 0, '0},
    '{0, 8, 0, 0, 0, 0, 0, '0},
    '{8, 8, 0, 0, 0, 0, 0, '0},
    '{8, 0, 0, 0, 1, 0, 0, '0},
    '{2, 2, 0, 0, 0, 0, 0, '0},
    '{2, 4, 0, 0, 0, 0, 0, '0},
    '{4, 4, 0, 0, 0, 0, 0, '0},
    '{4, 2, 0, 0, 1, 1, 1, '{60, 0, 8, 0, 8, 0}},
    // single-vertex path flips the sign; batch end closes the square,
    // negative sum clamps
    '{3, 3, 1, 1, 1, 0, 0, '0},
    '{0, 0, 0, 0, 0, 0, 0, '0},
    '{0, 4, 0, 0, 0, 0, 0, '0},
    '{4, 4, 0, 0, 0, 0, 0, '0},
    '{4, 0, 0, 0, 0, 1, 1, '{1, 0, 4, 0, 4, 0}},
    // append onto the kept clamp; batch start drops the open path
    '{1, 1, 1, 0, 0, 0, 0, '0},
    '{9, 1, 0, 0, 0, 0, 0, '0},
    '{0, 0, 1, 0, 0, 0, 0, '0},
    '{0, 4, 0, 0, 0, 0, 0, '0},
    '{4, 4, 0, 0, 0, 0, 0, '0},
    '{4, 0, 0, 0, 0, 1, 1, '{25, 0, 9, 0, 4, 0}},
    // opposite corners of the coordinate range
    '{CMIN, CMAX, 1, 1, 0, 0, 0, '0},
    '{CMAX, CMIN, 0, 0, 0, 1, 1, '{1, CMIN, CMAX, CMIN, CMAX, 0}}
  };

  // Result side: random stalls with calm windows, plus one long hold-off
  // when the sender asks for it.
  initial begin
    int unsigned holds_done, rx_cycle;
    int          stall_left;
    holds_done = 0;
    rx_cycle   = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (holds_done < hold_ask) begin
        holds_done++;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (rx_cycle % 1024 >= 256 && $urandom_range(0, 2) == 0) stall_left = pick_idle();
      end
    end
  end

  initial begin
    vertex_req_t v;
    int          sent;
    sent = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_table[i]) send_vertex(dir_table[i]);

    // Hold the result side while single-vertex batches keep coming.
    hold_ask++;
    sender_calm = 1'b1;
    repeat (24) begin
      v = '0;
      v.x            = pick_coord(1);
      v.y            = pick_coord(1);
      v.batch_start  = 1'b1;
      v.clear_totals = ($urandom_range(0, 1) == 1);
      v.path_end     = ($urandom_range(0, 1) == 1);
      v.batch_end    = 1'b1;
      send_vertex(v);
    end
    sender_calm = 1'b0;

    sweep_to_limit(1'b1);
    sweep_to_limit(1'b0);

    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 8) begin
        // stray vertex with arbitrary flags
        v = '0;
        v.x            = pick_coord($urandom_range(0, 2));
        v.y            = pick_coord($urandom_range(0, 2));
        v.batch_start  = ($urandom_range(0, 1) == 1);
        v.clear_totals = ($urandom_range(0, 1) == 1);
        v.path_end     = ($urandom_range(0, 1) == 1);
        v.batch_end    = ($urandom_range(0, 1) == 1);
        send_vertex(v);
        sent++;
      end else begin
        random_batch(sent);
      end
    end

    s_tvalid <= 1'b0;
    while (pending_areas.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d vertices and %0d results, %0d of them saturated.",
             vertices_in, results_seen, sat_results);
    $display("Input held back by the block on %0d cycles.", input_stalls);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("Run limit reached with %0d results still pending.", pending_areas.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
